// ===== hdl/lfps_pkg.sv =====
// Shared types, constants and the lamp lookup table for the line-follow PID steering block.
package lfps_pkg;

	// Width of the saturating integral accumulator.
	localparam int SUM_BITS = 24;

	localparam int PATTERN_W = 8;
	localparam int SPEED_W   = 7;
	localparam int ERR_W     = 7;
	localparam int DIFF_W    = ERR_W + 1;
	localparam int GAIN_W    = 16;
	localparam int CORR_W    = 16;
	localparam int DRIVE_W   = 8;

	// Product widths: each gain is unsigned, so it gains a zero sign bit.
	localparam int P_PROD_W = GAIN_W + 1 + ERR_W;
	localparam int I_PROD_W = GAIN_W + 1 + SUM_BITS;
	localparam int D_PROD_W = GAIN_W + 1 + DIFF_W;
	// The integral product is held at +/- 2^61 once it could exceed that.
	localparam int ITERM_LIM_EXP = 61;
	localparam int ITERM_W = (I_PROD_W > ITERM_LIM_EXP + 1) ? ITERM_LIM_EXP + 2 : I_PROD_W;
	localparam int ACC_W   = ITERM_W + 2;

	// Division by 2560 = 512 * 5: shift by 9, then multiply by ceil(2^18 / 5).
	// The reciprocal is exact for every dividend below 2^18, and any quotient of
	// 32768 or more saturates anyway, so the shifted value is cut at 5 * 32768.
	localparam int DIV_SHIFT   = 9;
	localparam int X_W         = 18;
	localparam int RECIP_SHIFT = 18;
	localparam int RECIP_W     = 16;
	localparam logic [RECIP_W-1:0] DIV5_RECIP = 16'd52429;
	localparam int SAT_X       = 5 * 32768;

	localparam int DRIVE_LIMIT = 100;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [GAIN_W-1:0] KP_RESET = 16'd5120;
	localparam logic [GAIN_W-1:0] KI_RESET = 16'd15;
	localparam logic [GAIN_W-1:0] KD_RESET = 16'd4864;

	typedef enum logic [1:0] {
		REG_GAIN_P = 2'd0,
		REG_GAIN_I = 2'd1,
		REG_GAIN_D = 2'd2
	} reg_index_t;

	typedef logic signed [SUM_BITS-1:0] sum_t;

	localparam sum_t SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
	localparam sum_t SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

	typedef struct packed {
		logic [GAIN_W-1:0] kp;
		logic [GAIN_W-1:0] ki;
		logic [GAIN_W-1:0] kd;
	} gains_t;

	typedef struct packed {
		logic                    hit;
		logic signed [ERR_W-1:0] err;
	} lookup_t;

	// One classified sensor word, as handed from the front end to the back end.
	typedef struct packed {
		logic                     hit;
		logic signed [ERR_W-1:0]  err;
		sum_t                     sum;
		logic signed [DIFF_W-1:0] diff;
		logic [SPEED_W-1:0]       speed;
	} item_t;

	// Line position in tenths of a lamp for single-lamp and double-lamp patterns.
	function automatic lookup_t lamp_lookup(input logic [PATTERN_W-1:0] pattern);
		lookup_t r;
		r.hit = 1'b1;
		case (pattern)
			8'hEF: r.err = -7'sd20;
			8'hF7: r.err =  7'sd20;
			8'hDF: r.err = -7'sd25;
			8'hBF: r.err = -7'sd30;
			8'h7F: r.err = -7'sd32;
			8'hFB: r.err =  7'sd25;
			8'hFD: r.err =  7'sd30;
			8'hFE: r.err =  7'sd32;
			8'hCF: r.err = -7'sd20;
			8'h9F: r.err = -7'sd26;
			8'h3F: r.err = -7'sd32;
			8'hF3: r.err =  7'sd20;
			8'hF9: r.err =  7'sd26;
			8'hFC: r.err =  7'sd32;
			default: begin
				r.hit = 1'b0;
				r.err = '0;
			end
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/line_follow_pid_steering.sv =====
// Top level of the line-follow PID steering block: gain registers, front end, queue, back end.
//
// Each input word carries an 8-lamp sensor byte (lamp_pattern, a clear bit is a lamp over
// the line) and a forward speed (base_speed). A word is taken at a rising edge with
// item_valid high and item_stall low. Each word yields exactly one result word on the
// result channel, taken when result_valid is high and result_stall is low.
// A known single-lamp or double-lamp pattern runs one PID step and raises steering_active;
// any other pattern clears the integral and previous error and drives straight.
// The three gains are written through cfg_valid/cfg_ready with cfg_index 0, 1, 2 for the
// proportional, integral and derivative gain; cfg_ready is always high, other indexes
// are ignored. Write gains only while no word is in flight.
// Throughput is one word per cycle while the receiver does not stall. A taken word passes
// through the queue, then the gain multipliers, the sum and scale, the divide by five,
// and the result register. The queue holds four words.
// Reset clears the PID state, loads the default gains and empties the pipeline.
// When the receiver stalls, the result register holds, the stages behind it fill, then
// the queue fills and item_stall rises.
module line_follow_pid_steering (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic [lfps_pkg::PATTERN_W-1:0]      lamp_pattern,
	input  logic [lfps_pkg::SPEED_W-1:0]        base_speed,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic                                steering_active,
	output logic signed [lfps_pkg::CORR_W-1:0]  correction,
	output logic signed [lfps_pkg::DRIVE_W-1:0] left_drive,
	output logic signed [lfps_pkg::DRIVE_W-1:0] right_drive,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [1:0]                          cfg_index,
	input  logic [lfps_pkg::GAIN_W-1:0]         cfg_data
);
	import lfps_pkg::*;

	gains_t gains_q;
	item_t  front_item;
	item_t  head_item;
	logic   q_full, q_nonempty, q_push, q_pop, back_ready;

	// Configuration writes are registered as they arrive, so the port never pushes back.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.kp <= KP_RESET;
			gains_q.ki <= KI_RESET;
			gains_q.kd <= KD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_index_t'(cfg_index))
				REG_GAIN_P: gains_q.kp <= cfg_data;
				REG_GAIN_I: gains_q.ki <= cfg_data;
				REG_GAIN_D: gains_q.kd <= cfg_data;
				default: ;
			endcase
		end
	end

	// The stall comes straight from the queue occupancy register.
	assign item_stall = q_full;
	assign q_push     = item_valid && !q_full;
	assign q_pop      = q_nonempty && back_ready;

	lfps_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (q_push),
		.lamp_pattern (lamp_pattern),
		.base_speed   (base_speed),
		.item         (front_item)
	);

	lfps_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_item  (front_item),
		.pop      (q_pop),
		.rd_item  (head_item),
		.full     (q_full),
		.nonempty (q_nonempty)
	);

	lfps_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.gains           (gains_q),
		.in_valid        (q_nonempty),
		.in_ready        (back_ready),
		.item            (head_item),
		.result_stall    (result_stall),
		.result_valid    (result_valid),
		.steering_active (steering_active),
		.correction      (correction),
		.left_drive      (left_drive),
		.right_drive     (right_drive)
	);

	// Driving straight means no correction and equal wheel commands.
	a_straight: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !steering_active |-> correction == '0 && left_drive == right_drive)
		else $error("straight result carries a correction");

	// Wheel commands always stay inside the drive limit.
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> left_drive <= 8'sd100 && left_drive >= -8'sd100
			&& right_drive <= 8'sd100 && right_drive >= -8'sd100)
		else $error("wheel command outside the drive limit");

	// The input stalls only after the queue grew without draining.
	a_stall_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(item_stall) |-> $past(q_push && !q_pop))
		else $error("input stall rose without queue growth");

endmodule

// ===== hdl/lfps_front.sv =====
// Front end: classifies each sensor word and advances the integral and previous-error state.
module lfps_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic [lfps_pkg::PATTERN_W-1:0] lamp_pattern,
	input  logic [lfps_pkg::SPEED_W-1:0]   base_speed,
	output lfps_pkg::item_t                item
);
	import lfps_pkg::*;

	lookup_t                 look;
	sum_t                    error_sum_q;
	logic signed [ERR_W-1:0] last_error_q;
	logic signed [SUM_BITS:0] sum_wide;
	sum_t                    sum_next;

	always_comb begin
		look     = lamp_lookup(lamp_pattern);
		sum_wide = {error_sum_q[SUM_BITS-1], error_sum_q}
			+ {{(SUM_BITS+1-ERR_W){look.err[ERR_W-1]}}, look.err};
		// The two top bits differ only when the sum left the accumulator range.
		if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
			sum_next = sum_wide[SUM_BITS] ? SUM_MIN : SUM_MAX;
		end else begin
			sum_next = sum_wide[SUM_BITS-1:0];
		end
		item.hit   = look.hit;
		item.err   = look.err;
		item.sum   = sum_next;
		item.diff  = {look.err[ERR_W-1], look.err} - {last_error_q[ERR_W-1], last_error_q};
		item.speed = base_speed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q  <= '0;
			last_error_q <= '0;
		end else if (push) begin
			if (look.hit) begin
				error_sum_q  <= sum_next;
				last_error_q <= look.err;
			end else begin
				error_sum_q  <= '0;
				last_error_q <= '0;
			end
		end
	end

endmodule

// ===== hdl/lfps_queue.sv =====
// Short first-in first-out queue of classified words between the front and back ends.
module lfps_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lfps_pkg::item_t wr_item,
	input  logic            pop,
	output lfps_pkg::item_t rd_item,
	output logic            full,
	output logic            nonempty
);
	import lfps_pkg::*;

	item_t             slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full     = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign nonempty = (count_q != '0);
	assign rd_item  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/lfps_back.sv =====
// Back end: four-stage PID arithmetic pipeline ending in the result register.
module lfps_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lfps_pkg::gains_t                  gains,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  lfps_pkg::item_t                   item,
	input  logic                              result_stall,
	output logic                              result_valid,
	output logic                              steering_active,
	output logic signed [lfps_pkg::CORR_W-1:0]  correction,
	output logic signed [lfps_pkg::DRIVE_W-1:0] left_drive,
	output logic signed [lfps_pkg::DRIVE_W-1:0] right_drive
);
	import lfps_pkg::*;

	logic en_s1, en_s2, en_s3, en_s4;
	logic v_s1, v_s2, v_s3, v_s4;

	// Stage 1: the three gain products.
	logic                       hit_s1;
	logic [SPEED_W-1:0]         speed_s1;
	logic signed [P_PROD_W-1:0] p_prod_s1;
	logic signed [I_PROD_W-1:0] i_prod_s1;
	logic signed [D_PROD_W-1:0] d_prod_s1;

	// Stage 2: magnitude of the sum, pre-shifted by 512.
	logic               hit_s2, neg_s2, big_s2;
	logic [SPEED_W-1:0] speed_s2;
	logic [X_W-1:0]     x_s2;

	// Stage 3: quotient magnitude.
	logic               hit_s3, neg_s3, big_s3;
	logic [SPEED_W-1:0] speed_s3;
	logic [CORR_W-1:0]  q_s3;

	// Stage 4: the result register.
	logic                      active_s4;
	logic signed [CORR_W-1:0]  corr_s4;
	logic signed [DRIVE_W-1:0] left_s4, right_s4;

	logic signed [ITERM_W-1:0] iterm_c;
	logic signed [ACC_W-1:0]   acc_c;
	logic [ACC_W-1:0]          mag_c;
	logic [X_W+RECIP_W-1:0]    recip_prod_c;
	logic signed [CORR_W-1:0]  corr_c;
	logic signed [CORR_W:0]    left_sum_c, right_sum_c;
	logic signed [DRIVE_W-1:0] left_c, right_c;

	assign en_s4    = !v_s4 || !result_stall;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	generate
		if (I_PROD_W > ITERM_LIM_EXP + 1) begin : g_iterm_clamp
			localparam logic signed [I_PROD_W-1:0] ILIM = I_PROD_W'(1) << ITERM_LIM_EXP;
			always_comb begin
				if (i_prod_s1 > ILIM) begin
					iterm_c = ITERM_W'(ILIM);
				end else if (i_prod_s1 < -ILIM) begin
					iterm_c = ITERM_W'(-ILIM);
				end else begin
					iterm_c = i_prod_s1[ITERM_W-1:0];
				end
			end
		end else begin : g_iterm_plain
			assign iterm_c = i_prod_s1;
		end
	endgenerate

	always_comb begin
		acc_c = ACC_W'(p_prod_s1) + ACC_W'(iterm_c) + ACC_W'(d_prod_s1);
		mag_c = acc_c[ACC_W-1] ? ACC_W'(-acc_c) : ACC_W'(acc_c);

		recip_prod_c = x_s2 * DIV5_RECIP;

		if (!hit_s3) begin
			corr_c = '0;
		end else if (big_s3) begin
			corr_c = neg_s3 ? {1'b1, {(CORR_W-1){1'b0}}} : {1'b0, {(CORR_W-1){1'b1}}};
		end else begin
			corr_c = neg_s3 ? -$signed(q_s3) : $signed(q_s3);
		end
		left_sum_c  = $signed({{(CORR_W+1-SPEED_W){1'b0}}, speed_s3})
			+ {corr_c[CORR_W-1], corr_c};
		right_sum_c = $signed({{(CORR_W+1-SPEED_W){1'b0}}, speed_s3})
			- {corr_c[CORR_W-1], corr_c};
		if (left_sum_c > (CORR_W+1)'(DRIVE_LIMIT)) begin
			left_c = DRIVE_W'(DRIVE_LIMIT);
		end else if (left_sum_c < -(CORR_W+1)'(DRIVE_LIMIT)) begin
			left_c = -DRIVE_W'(DRIVE_LIMIT);
		end else begin
			left_c = left_sum_c[DRIVE_W-1:0];
		end
		if (right_sum_c > (CORR_W+1)'(DRIVE_LIMIT)) begin
			right_c = DRIVE_W'(DRIVE_LIMIT);
		end else if (right_sum_c < -(CORR_W+1)'(DRIVE_LIMIT)) begin
			right_c = -DRIVE_W'(DRIVE_LIMIT);
		end else begin
			right_c = right_sum_c[DRIVE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			hit_s1    <= item.hit;
			speed_s1  <= item.speed;
			p_prod_s1 <= $signed({1'b0, gains.kp}) * item.err;
			i_prod_s1 <= $signed({1'b0, gains.ki}) * item.sum;
			d_prod_s1 <= $signed({1'b0, gains.kd}) * item.diff;
		end
		if (en_s2) begin
			hit_s2   <= hit_s1;
			speed_s2 <= speed_s1;
			neg_s2   <= acc_c[ACC_W-1];
			big_s2   <= mag_c[ACC_W-1:DIV_SHIFT] >= (ACC_W-DIV_SHIFT)'(SAT_X);
			x_s2     <= mag_c[DIV_SHIFT +: X_W];
		end
		if (en_s3) begin
			hit_s3   <= hit_s2;
			speed_s3 <= speed_s2;
			neg_s3   <= neg_s2;
			big_s3   <= big_s2;
			q_s3     <= recip_prod_c[RECIP_SHIFT +: CORR_W];
		end
		if (en_s4) begin
			active_s4 <= hit_s3;
			corr_s4   <= corr_c;
			left_s4   <= left_c;
			right_s4  <= right_c;
		end
	end

	assign result_valid    = v_s4;
	assign steering_active = active_s4;
	assign correction      = corr_s4;
	assign left_drive      = left_s4;
	assign right_drive     = right_s4;

endmodule

// ===== sim/line_follow_pid_steering_tb.sv =====
// Self-checking testbench for the line-follow PID steering block with its own steering predictor.
`timescale 1ns / 1ps

module line_follow_pid_steering_tb;
	import lfps_pkg::*;

	// One sensor word as offered on the input channel.
	typedef struct packed {
		logic [PATTERN_W-1:0] pattern;
		logic [SPEED_W-1:0]   speed;
	} sensor_word_t;

	// One steering word as returned on the result channel.
	typedef struct packed {
		logic                      active;
		logic signed [CORR_W-1:0]  corr;
		logic signed [DRIVE_W-1:0] left;
		logic signed [DRIVE_W-1:0] right;
	} steer_word_t;

	// A sensor pattern that the block recognizes and its line offset in tenths of a lamp.
	typedef struct packed {
		logic [PATTERN_W-1:0]    pattern;
		logic signed [ERR_W-1:0] tenths;
	} line_spot_t;

	// The line is left of center in the first seven entries and right of center in the rest,
	// so a run of steering on one side can be drawn from one half of the table.
	localparam int SIDE_SPOTS = 7;
	localparam line_spot_t LINE_TABLE [14] = '{
		'{8'hEF, -7'sd20}, '{8'hDF, -7'sd25}, '{8'hBF, -7'sd30}, '{8'h7F, -7'sd32},
		'{8'hCF, -7'sd20}, '{8'h9F, -7'sd26}, '{8'h3F, -7'sd32},
		'{8'hF7,  7'sd20}, '{8'hFB,  7'sd25}, '{8'hFD,  7'sd30}, '{8'hFE,  7'sd32},
		'{8'hF3,  7'sd20}, '{8'hF9,  7'sd26}, '{8'hFC,  7'sd32}
	};

	// The sum of the three gain products is in units of 1/2560 of a drive unit.
	localparam longint SCALE_DIV  = 2560;
	localparam longint ITERM_CAP  = longint'(1) << 61;
	localparam longint CORR_MAX   = 32767;
	localparam longint CORR_MIN   = -32768;

	// Index three does not address any gain, so a write to it must leave all gains alone.
	localparam logic [1:0] REG_SPARE = 2'd3;

	// Idling modes: none, sender mostly idle, receiver mostly stalling, and both at once.
	localparam int SEND_IDLE_PCT [4] = '{0, 74, 0, 29};
	localparam int STALL_PCT     [4] = '{0, 0, 74, 29};

	localparam int PHASE_WORDS   = 135;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 10;
	localparam int CYCLE_LIMIT   = 200000;

	localparam sensor_word_t DIRECTED_WORDS [24] = '{
		{8'hFF, 7'd0},   {8'h00, 7'd100}, {8'hEF, 7'd50},  {8'hF7, 7'd50},
		{8'hDF, 7'd60},  {8'hBF, 7'd60},  {8'h7F, 7'd100}, {8'h7F, 7'd100},
		{8'hFB, 7'd127}, {8'hFD, 7'd101}, {8'hFE, 7'd0},   {8'hFE, 7'd0},
		{8'hCF, 7'd30},  {8'h9F, 7'd30},  {8'h3F, 7'd80},  {8'hF3, 7'd80},
		{8'hF9, 7'd1},   {8'hFC, 7'd99},  {8'hAA, 7'd127}, {8'h55, 7'd101},
		{8'hFC, 7'd100}, {8'h3F, 7'd100}, {8'hE7, 7'd40},  {8'h7E, 7'd64}
	};

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      item_valid = 1'b0;
	logic                      item_stall;
	logic [PATTERN_W-1:0]      lamp_pattern = '0;
	logic [SPEED_W-1:0]        base_speed = '0;
	logic                      result_valid;
	logic                      result_stall = 1'b0;
	logic                      steering_active;
	logic signed [CORR_W-1:0]  correction;
	logic signed [DRIVE_W-1:0] left_drive;
	logic signed [DRIVE_W-1:0] right_drive;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [1:0]                cfg_index = '0;
	logic [GAIN_W-1:0]         cfg_data = '0;

	// Words still to be offered, and steering words predicted but not yet returned.
	sensor_word_t pending_words[$];
	steer_word_t  expected_steering[$];
	sensor_word_t next_word;
	steer_word_t  want;
	steer_word_t  got;

	// The predictor's copy of the gains and of the PID state.
	logic [GAIN_W-1:0]       gain_p = KP_RESET;
	logic [GAIN_W-1:0]       gain_i = KI_RESET;
	logic [GAIN_W-1:0]       gain_d = KD_RESET;
	sum_t                    line_sum = '0;
	logic signed [ERR_W-1:0] line_last = '0;

	bit word_taken = 1'b0;
	int mismatch_count = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int cycle_count = 0;

	line_follow_pid_steering DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.lamp_pattern    (lamp_pattern),
		.base_speed      (base_speed),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.steering_active (steering_active),
		.correction      (correction),
		.left_drive      (left_drive),
		.right_drive     (right_drive),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Works out the steering word for one sensor word and advances the PID state.
	// A pattern outside the table clears the state and drives straight at the base speed, held to the drive limit.
	function automatic steer_word_t steer_step(input logic [PATTERN_W-1:0] pattern,
			input logic [SPEED_W-1:0] speed);
		steer_word_t r;
		bit          hit;
		longint      e;
		longint      d;
		longint      s;
		longint      mag;
		longint      iterm;
		longint      acc;
		longint      q;
		longint      lft;
		longint      rgt;
		hit = 1'b0;
		e = 0;
		q = 0;
		for (int n = 0; n < 14; n++) begin
			if (LINE_TABLE[n].pattern == pattern) begin
				hit = 1'b1;
				e = LINE_TABLE[n].tenths;
			end
		end
		if (!hit) begin
			line_sum = '0;
			line_last = '0;
		end else begin
			// The integral saturates at the accumulator's signed range.
			s = longint'(line_sum) + e;
			if (s > longint'(SUM_MAX))
				s = longint'(SUM_MAX);
			else if (s < longint'(SUM_MIN))
				s = longint'(SUM_MIN);
			line_sum = sum_t'(s);
			d = e - longint'(line_last);
			line_last = e[ERR_W-1:0];
			// The integral product is held at 2^61 with its sign once it would pass that.
			mag = (s < 0) ? -s : s;
			if (gain_i != 0 && mag > ITERM_CAP / longint'(gain_i))
				iterm = (s < 0) ? -ITERM_CAP : ITERM_CAP;
			else
				iterm = longint'(gain_i) * s;
			acc = longint'(gain_p) * e + iterm + longint'(gain_d) * d;
			// Signed division truncates toward zero, as the block does.
			q = acc / SCALE_DIV;
			if (q > CORR_MAX)
				q = CORR_MAX;
			else if (q < CORR_MIN)
				q = CORR_MIN;
		end
		lft = longint'(speed) + q;
		rgt = longint'(speed) - q;
		if (lft > DRIVE_LIMIT)
			lft = DRIVE_LIMIT;
		else if (lft < -DRIVE_LIMIT)
			lft = -DRIVE_LIMIT;
		if (rgt > DRIVE_LIMIT)
			rgt = DRIVE_LIMIT;
		else if (rgt < -DRIVE_LIMIT)
			rgt = -DRIVE_LIMIT;
		r.active = hit;
		r.corr = q[CORR_W-1:0];
		r.left = lft[DRIVE_W-1:0];
		r.right = rgt[DRIVE_W-1:0];
		return r;
	endfunction

	// Sender. A new word is put up only when the channel is empty or the last word was just
	// taken; a word that is stalled stays on the bus unchanged, with valid held high.
	always @(negedge clk) begin
		if (arst_n && (!item_valid || word_taken)) begin
			if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				next_word = pending_words.pop_front();
				item_valid <= 1'b1;
				lamp_pattern <= next_word.pattern;
				base_speed <= next_word.speed;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Long hold-off of the receiver. While it runs the sender keeps offering words, so the
	// result register, the pipeline and then the input queue fill and item_stall must rise.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_served < hold_requests) begin
			hold_left <= HOLD_CYCLES;
			hold_served <= hold_served + 1;
		end
	end

	// Receiver. It stalls at random, or for the whole of a hold-off.
	always @(negedge clk) begin
		result_stall <= (hold_left != 0) || ($urandom_range(0, 99) < stall_pct);
	end

	// Monitor. Every sensor word taken gets a predicted steering word at the moment it is
	// taken, and every steering word taken is checked against the oldest prediction.
	always @(posedge clk) begin
		word_taken = arst_n && item_valid && !item_stall;
		if (arst_n && result_valid && !result_stall) begin
			got.active = steering_active;
			got.corr = correction;
			got.left = left_drive;
			got.right = right_drive;
			if (expected_steering.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected steering word: active=%0b corr=%0d left=%0d right=%0d",
						got.active, got.corr, got.left, got.right);
			end else begin
				want = expected_steering.pop_front();
				if (got.active !== want.active || got.corr !== want.corr ||
						got.left !== want.left || got.right !== want.right) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$write("steering mismatch: expected active=%0b corr=%0d left=%0d right=%0d, ",
							want.active, want.corr, want.left, want.right);
						$display("got active=%0b corr=%0d left=%0d right=%0d",
							got.active, got.corr, got.left, got.right);
					end
				end
			end
		end
		if (word_taken)
			expected_steering.push_back(steer_step(lamp_pattern, base_speed));
	end

	// Watchdog for a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Waits until every word has been offered, taken and answered, then lets the pipeline
	// settle. Checked just after the falling edge, once the sender's update for that edge
	// has landed and clear of the monitor.
	task automatic wait_drained;
		do begin
			@(negedge clk);
			#1;
		end while (pending_words.size() != 0 || item_valid || expected_steering.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Writes one gain register and mirrors the write into the predictor.
	task automatic write_gain(input logic [1:0] idx, input logic [GAIN_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_GAIN_P: gain_p = value;
			REG_GAIN_I: gain_i = value;
			REG_GAIN_D: gain_d = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// One phase of random stimulus. Gains are only loaded once the block has gone idle.
	// Most words come in runs that keep the line on one side, so the integral grows and
	// the correction can reach saturation; some runs are noise that clears the PID state,
	// and a few words inside a run jump to the other side to kick the derivative.
	task automatic run_phase(input bit load_gains, input logic [GAIN_W-1:0] kp,
			input logic [GAIN_W-1:0] ki, input logic [GAIN_W-1:0] kd, input int mode,
			input int run_max);
		sensor_word_t w;
		int           made;
		int           run_left;
		int           side;
		int           pick;
		bit           noise_run;
		made = 0;
		run_left = 0;
		side = 0;
		noise_run = 1'b0;
		if (load_gains) begin
			wait_drained();
			write_gain(REG_GAIN_P, kp);
			write_gain(REG_GAIN_I, ki);
			write_gain(REG_GAIN_D, kd);
			write_gain(REG_SPARE, GAIN_W'($urandom));
		end
		@(posedge clk);
		send_idle_pct = SEND_IDLE_PCT[mode];
		stall_pct = STALL_PCT[mode];
		if (mode == 0)
			hold_requests++;
		while (made < PHASE_WORDS) begin
			if (run_left == 0) begin
				noise_run = ($urandom_range(0, 99) < 20);
				side = $urandom_range(0, 1);
				run_left = noise_run ? $urandom_range(1, 3) : $urandom_range(1, run_max);
			end
			if (noise_run || $urandom_range(0, 99) < 3) begin
				case ($urandom_range(0, 3))
					0: w.pattern = 8'h00;
					1: w.pattern = 8'hFF;
					default: w.pattern = PATTERN_W'($urandom);
				endcase
			end else begin
				pick = ($urandom_range(0, 99) < 20) ? 1 - side : side;
				w.pattern = LINE_TABLE[pick * SIDE_SPOTS + $urandom_range(0, SIDE_SPOTS - 1)].pattern;
			end
			// Speeds above 100 are legal on the port and must saturate in the drives.
			w.speed = ($urandom_range(0, 9) == 0) ? SPEED_W'($urandom_range(101, 127)) :
				SPEED_W'($urandom_range(0, 100));
			pending_words.push_back(w);
			run_left--;
			made++;
		end
	endtask

	initial begin
		// Reset is held low at the start and then released away from the rising edge.
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed words first, with the gains as reset left them: both all-dark and
		// all-lit patterns, every table pattern, patterns outside the table, speeds at
		// zero, at 100 and above it, and sharp swings from one side of the line to the
		// other. The random part of this phase runs without idling and with a hold-off.
		foreach (DIRECTED_WORDS[n])
			pending_words.push_back(DIRECTED_WORDS[n]);
		run_phase(1'b0, KP_RESET, KI_RESET, KD_RESET, 0, 30);

		// Largest gains: the integral term drives the correction into saturation.
		run_phase(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 60);
		// Zero gains: every table hit must still steer with a zero correction.
		run_phase(1'b1, 16'h0000, 16'h0000, 16'h0000, 2, 20);
		run_phase(1'b1, GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom), 3, 40);
		run_phase(1'b1, GAIN_W'($urandom), GAIN_W'($urandom_range(0, 255)),
			GAIN_W'($urandom), 0, 40);
		run_phase(1'b1, 16'h0001, 16'hFFFF, 16'h0000, 1, 60);
		run_phase(1'b1, KP_RESET, KI_RESET, KD_RESET, 2, 30);

		wait_drained();
		if (mismatch_count == 0 && expected_steering.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/lfps_pkg.sv
hdl/lfps_front.sv
hdl/lfps_queue.sv
hdl/lfps_back.sv
hdl/line_follow_pid_steering.sv
sim/line_follow_pid_steering_tb.sv
